### rtl/core/stia_pkg.sv
// Shared types, codes and helpers for the radix string-to-integer converter.
`default_nettype none

package stia_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int ALPHA_CHARS = 16;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int MAG_W       = 32;
    localparam int ACC_W       = MAG_W + RADIX_W;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_LENGTH = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_ALPHABET = 2'd1;
    localparam logic [1:0] ST_RANGE        = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_STOP
    } phase_t;

    typedef logic [ALPHA_CHARS-1:0][7:0] alphabet_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } char_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } result_item_t;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

### rtl/core/string_to_int_any_base.sv
// Top level: streaming string-to-int32 converter with a configurable digit alphabet.
// A terminator is first registered at the input; its result is registered once the output is free.
// Throughput: one character per cycle unless a terminator meets a stalled result; one char-to-state update per cycle
//   (alphabet compare, 32x5 multiply-add and limit compare between input and state regs).
// Alphabet validity is re-evaluated into a register in the cycle after a config write.
// Reset (async, active low): alphabet registers and parse state clear, no result pending,
//   alphabet flagged invalid until configured.
`default_nettype none

module string_to_int_any_base (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   char_valid,
    output logic                                  char_ready,
    input  stia_pkg::char_item_t                  char_data,
    output logic                                  result_valid,
    input  wire                                   result_ready,
    output stia_pkg::result_item_t                result_data,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [stia_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [stia_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic                               s1_valid_reg;
    stia_pkg::char_item_t               s1_item_reg;

    logic [stia_pkg::CFG_DATA_W-1:0]    alpha_low_reg;
    logic [stia_pkg::CFG_DATA_W-1:0]    alpha_high_reg;
    logic [stia_pkg::RADIX_W-1:0]       alpha_len_reg;
    logic                               alpha_bad_reg;
    logic                               alpha_bad_next;

    stia_pkg::phase_t                   phase_reg;
    stia_pkg::phase_t                   phase_next;
    logic                               negative_reg;
    logic                               negative_next;
    logic [stia_pkg::MAG_W-1:0]         magnitude_reg;
    logic [stia_pkg::MAG_W-1:0]         magnitude_next;
    logic                               overflowed_reg;
    logic                               overflowed_next;

    logic                               result_valid_reg;
    stia_pkg::result_item_t             result_reg;
    stia_pkg::result_item_t             result_next;

    stia_pkg::alphabet_t                alpha;
    logic [stia_pkg::RADIX_W-1:0]       radix;
    logic                               digit_hit;
    logic [stia_pkg::DIGIT_W-1:0]       digit;
    logic [stia_pkg::ACC_W-1:0]         acc;
    logic                               acc_over;

    logic                               out_free;
    logic                               s1_fire;
    logic                               s1_end_fire;

    assign cfg_ready = 1'b1;

    assign out_free    = !result_valid_reg || result_ready;
    assign s1_fire     = s1_valid_reg && (!s1_item_reg.end_of_string || out_free);
    assign s1_end_fire = s1_fire && s1_item_reg.end_of_string;
    assign char_ready  = !s1_valid_reg || s1_fire;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign alpha = {alpha_high_reg, alpha_low_reg};
    assign radix = (alpha_len_reg > stia_pkg::RADIX_W'(stia_pkg::MAX_RADIX))
                 ? stia_pkg::RADIX_W'(stia_pkg::MAX_RADIX) : alpha_len_reg;

    // first matching alphabet position wins
    always_comb
    begin
        digit_hit = 1'b0;
        digit     = '0;
        for (int k = stia_pkg::ALPHA_CHARS - 1; k >= 0; k--)
        begin
            if ((stia_pkg::RADIX_W'(k) < radix) && (alpha[k] == s1_item_reg.char_byte))
            begin
                digit_hit = 1'b1;
                digit     = stia_pkg::DIGIT_W'(k);
            end
        end
    end

    assign acc = stia_pkg::ACC_W'(magnitude_reg) * stia_pkg::ACC_W'(radix)
               + stia_pkg::ACC_W'(digit);
    assign acc_over = acc > stia_pkg::ACC_W'(stia_pkg::MAG_LIMIT);

    always_comb
    begin
        logic [7:0] c;
        logic       bad;
        bad = (alpha_len_reg < stia_pkg::RADIX_W'(2))
           || (alpha_len_reg > stia_pkg::RADIX_W'(stia_pkg::MAX_RADIX));
        for (int a = 0; a < stia_pkg::ALPHA_CHARS; a++)
        begin
            c = alpha[a];
            if (stia_pkg::RADIX_W'(a) < alpha_len_reg)
            begin
                if ((c == stia_pkg::CH_NUL) || (c == stia_pkg::CH_PLUS)
                    || (c == stia_pkg::CH_MINUS) || stia_pkg::is_space(c))
                begin
                    bad = 1'b1;
                end
                for (int b = a + 1; b < stia_pkg::ALPHA_CHARS; b++)
                begin
                    if ((stia_pkg::RADIX_W'(b) < alpha_len_reg) && (alpha[b] == c))
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
        alpha_bad_next = bad;
    end

    // parse state: next state
    always_comb
    begin
        stia_pkg::phase_t ph;
        logic             take;
        logic [7:0]       c;
        ph              = phase_reg;
        take            = 1'b1;
        c               = s1_item_reg.char_byte;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        overflowed_next = overflowed_reg;
        if (s1_fire)
        begin
            if (s1_item_reg.end_of_string)
            begin
                phase_next      = stia_pkg::PH_SPACE;
                negative_next   = 1'b0;
                magnitude_next  = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                if (ph == stia_pkg::PH_SPACE)
                begin
                    if (stia_pkg::is_space(c))
                        take = 1'b0;
                    else
                        ph = stia_pkg::PH_SIGN;
                end
                if (take && (ph == stia_pkg::PH_SIGN))
                begin
                    if (c == stia_pkg::CH_PLUS)
                    begin
                        take = 1'b0;
                    end
                    else if (c == stia_pkg::CH_MINUS)
                    begin
                        negative_next = !negative_reg;
                        take          = 1'b0;
                    end
                    else
                    begin
                        ph = stia_pkg::PH_DIGIT;
                    end
                end
                if (take && (ph == stia_pkg::PH_DIGIT))
                begin
                    if (!digit_hit)
                        ph = stia_pkg::PH_STOP;
                    else if (!overflowed_reg)
                    begin
                        if (acc_over)
                            overflowed_next = 1'b1;
                        else
                            magnitude_next = acc[stia_pkg::MAG_W-1:0];
                    end
                end
                phase_next = ph;
            end
        end
    end

    // result for a terminator
    always_comb
    begin
        result_next.value  = '0;
        result_next.status = stia_pkg::ST_OK;
        if (alpha_bad_reg)
            result_next.status = stia_pkg::ST_BAD_ALPHABET;
        else if (overflowed_reg || (!negative_reg && magnitude_reg[stia_pkg::MAG_W-1]))
            result_next.status = stia_pkg::ST_RANGE;
        else if (negative_reg)
            result_next.value = $signed(32'd0 - magnitude_reg);
        else
            result_next.value = $signed(magnitude_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
            alpha_bad_reg  <= 1'b1;
        end
        else
        begin
            alpha_bad_reg <= alpha_bad_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    stia_pkg::CFG_ALPHABET_LOW:    alpha_low_reg  <= cfg_data;
                    stia_pkg::CFG_ALPHABET_HIGH:   alpha_high_reg <= cfg_data;
                    stia_pkg::CFG_ALPHABET_LENGTH: alpha_len_reg  <= cfg_data[stia_pkg::RADIX_W-1:0];
                    default:                       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= stia_pkg::PH_SPACE;
            negative_reg     <= 1'b0;
            magnitude_reg    <= '0;
            overflowed_reg   <= 1'b0;
        end
        else
        begin
            if (char_ready)
                s1_valid_reg <= char_valid;
            if (s1_end_fire)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
            overflowed_reg <= overflowed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            s1_item_reg <= char_data;
        if (s1_end_fire)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

### rtl/core/stia_checker.sv
// Port-level assertions for the string-to-int converter, bound to the top level.
`default_nettype none

module stia_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  char_valid,
    input wire                                  char_ready,
    input stia_pkg::char_item_t                 char_data,
    input wire                                  result_valid,
    input wire                                  result_ready,
    input stia_pkg::result_item_t               result_data
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.status != stia_pkg::ST_OK) |-> result_data.value == 0)
        else $error("nonzero value with error status");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.status == stia_pkg::ST_OK)
                      || (result_data.status == stia_pkg::ST_BAD_ALPHABET)
                      || (result_data.status == stia_pkg::ST_RANGE))
        else $error("illegal status code");

    // a fresh result comes only from a terminator accepted earlier at the input
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(char_valid && char_ready && char_data.end_of_string, 2))
        else $error("result without terminator transaction");

endmodule

bind string_to_int_any_base stia_checker u_stia_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

`default_nettype wire
